### src/mvta_pkg.sv
package mvta_pkg;

	localparam int VEC_LEN_DEF = 256;
	localparam int OP_W        = 2;
	localparam int IDX_W       = 8;
	localparam int ELEM_W      = 32;
	localparam int SUM_W       = 64;
	localparam int OQ_DEPTH    = 4;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD = 2'd0,
		OP_MAT  = 2'd1,
		OP_READ = 2'd2
	} op_t;

	typedef struct packed {
		logic [OP_W-1:0]          operation;
		logic [IDX_W-1:0]         row_index;
		logic [IDX_W-1:0]         col_index;
		logic signed [ELEM_W-1:0] element_value;
		logic signed [SUM_W-1:0]  row_sum_init;
		logic signed [SUM_W-1:0]  col_sum_init;
	} item_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] row_sum_out;
		logic signed [SUM_W-1:0] col_sum_out;
		logic                    saturated_seen;
	} result_t;

	typedef struct packed {
		logic s1_valid;
		logic s2_valid;
	} pipe_status_t;

endpackage

### src/mvta_if.sv
interface mvta_req_if;
	import mvta_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          operation;
	logic [IDX_W-1:0]         row_index;
	logic [IDX_W-1:0]         col_index;
	logic signed [ELEM_W-1:0] element_value;
	logic signed [SUM_W-1:0]  row_sum_init;
	logic signed [SUM_W-1:0]  col_sum_init;

	modport source (
		output valid, operation, row_index, col_index, element_value,
		       row_sum_init, col_sum_init,
		input  ready
	);
	modport sink (
		input  valid, operation, row_index, col_index, element_value,
		       row_sum_init, col_sum_init,
		output ready
	);
endinterface

interface mvta_rsp_if;
	import mvta_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [SUM_W-1:0] row_sum_out;
	logic signed [SUM_W-1:0] col_sum_out;
	logic                    saturated_seen;

	modport source (
		output valid, row_sum_out, col_sum_out, saturated_seen,
		input  ready
	);
	modport sink (
		input  valid, row_sum_out, col_sum_out, saturated_seen,
		output ready
	);
endinterface

### src/mvta_ram.sv
module mvta_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

### src/mvta_core.sv
module mvta_core #(
	parameter int VEC_LEN = mvta_pkg::VEC_LEN_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	input  mvta_pkg::item_t        item,
	output logic                   res_valid,
	output mvta_pkg::result_t      res,
	output mvta_pkg::pipe_status_t status
);
	import mvta_pkg::*;

	localparam int AW = $clog2(VEC_LEN);

	typedef struct packed {
		logic                     p_we;
		logic [AW-1:0]            p_addr;
		logic signed [ELEM_W-1:0] p_data;
		logic                     q_we;
		logic [AW-1:0]            q_addr;
		logic signed [SUM_W-1:0]  q_data;
		logic                     r_we;
		logic [AW-1:0]            r_addr;
		logic signed [SUM_W-1:0]  r_data;
	} wb_t;

	// returns {saturated, sum}
	function automatic logic [SUM_W:0] sat_add(input logic signed [SUM_W-1:0] a,
		input logic signed [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
		if (s[SUM_W] != s[SUM_W-1]) begin
			if (s[SUM_W]) begin
				return {1'b1, 1'b1, {(SUM_W-1){1'b0}}};
			end else begin
				return {1'b1, 1'b0, {(SUM_W-1){1'b1}}};
			end
		end
		return {1'b0, s[SUM_W-1:0]};
	endfunction

	// input decode
	logic          row_ok_in, col_ok_in;
	logic [AW-1:0] row_addr_in, col_addr_in, r_raddr_in;

	always_comb begin
		row_ok_in   = 32'(item.row_index) < VEC_LEN;
		col_ok_in   = 32'(item.col_index) < VEC_LEN;
		row_addr_in = AW'(item.row_index);
		col_addr_in = AW'(item.col_index);
		r_raddr_in  = (item.operation == OP_MAT) ? col_addr_in : row_addr_in;
	end

	// memory read data, valid in stage 1
	logic signed [ELEM_W-1:0] pc_rd, pr_rd;
	logic signed [SUM_W-1:0]  q_rd, r_rd;

	wb_t wr, wb1_q, wb2_q;

	mvta_ram #(.WIDTH(ELEM_W), .DEPTH(VEC_LEN)) u_p_col (
		.clk(clk), .we(wr.p_we), .waddr(wr.p_addr), .wdata(wr.p_data),
		.raddr(col_addr_in), .rdata(pc_rd)
	);
	mvta_ram #(.WIDTH(ELEM_W), .DEPTH(VEC_LEN)) u_p_row (
		.clk(clk), .we(wr.p_we), .waddr(wr.p_addr), .wdata(wr.p_data),
		.raddr(row_addr_in), .rdata(pr_rd)
	);
	mvta_ram #(.WIDTH(SUM_W), .DEPTH(VEC_LEN)) u_row_sums (
		.clk(clk), .we(wr.q_we), .waddr(wr.q_addr), .wdata(wr.q_data),
		.raddr(row_addr_in), .rdata(q_rd)
	);
	mvta_ram #(.WIDTH(SUM_W), .DEPTH(VEC_LEN)) u_col_sums (
		.clk(clk), .we(wr.r_we), .waddr(wr.r_addr), .wdata(wr.r_data),
		.raddr(r_raddr_in), .rdata(r_rd)
	);

	// stage 1
	logic                     valid_s1;
	logic [OP_W-1:0]          op_s1;
	logic                     row_ok_s1, col_ok_s1;
	logic [AW-1:0]            row_addr_s1, col_addr_s1, r_addr_s1;
	logic signed [ELEM_W-1:0] elem_s1;
	logic signed [SUM_W-1:0]  qi_s1, ri_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		op_s1       <= item.operation;
		row_ok_s1   <= row_ok_in;
		col_ok_s1   <= col_ok_in;
		row_addr_s1 <= row_addr_in;
		col_addr_s1 <= col_addr_in;
		r_addr_s1   <= r_raddr_in;
		elem_s1     <= item.element_value;
		qi_s1       <= item.row_sum_init;
		ri_s1       <= item.col_sum_init;
	end

	// p bypass: write in flight this cycle, then the one that hit the read edge
	logic signed [ELEM_W-1:0] pc_s1, pr_s1;
	logic signed [SUM_W-1:0]  prod_c_s1, prod_r_s1;

	always_comb begin
		if (wr.p_we && wr.p_addr == col_addr_s1) begin
			pc_s1 = wr.p_data;
		end else if (wb1_q.p_we && wb1_q.p_addr == col_addr_s1) begin
			pc_s1 = wb1_q.p_data;
		end else begin
			pc_s1 = pc_rd;
		end
		if (wr.p_we && wr.p_addr == row_addr_s1) begin
			pr_s1 = wr.p_data;
		end else if (wb1_q.p_we && wb1_q.p_addr == row_addr_s1) begin
			pr_s1 = wb1_q.p_data;
		end else begin
			pr_s1 = pr_rd;
		end
		prod_c_s1 = SUM_W'(elem_s1) * SUM_W'(pc_s1);
		prod_r_s1 = SUM_W'(elem_s1) * SUM_W'(pr_s1);
	end

	// stage 2
	logic                     valid_s2;
	logic [OP_W-1:0]          op_s2;
	logic                     row_ok_s2, col_ok_s2;
	logic [AW-1:0]            row_addr_s2, r_addr_s2;
	logic signed [ELEM_W-1:0] elem_s2;
	logic signed [SUM_W-1:0]  qi_s2, ri_s2, prod_c_s2, prod_r_s2, q_ram_s2, r_ram_s2;
	logic                     sat_q;

	always_ff @(posedge clk) begin
		op_s2       <= op_s1;
		row_ok_s2   <= row_ok_s1;
		col_ok_s2   <= col_ok_s1;
		row_addr_s2 <= row_addr_s1;
		r_addr_s2   <= r_addr_s1;
		elem_s2     <= elem_s1;
		qi_s2       <= qi_s1;
		ri_s2       <= ri_s1;
		prod_c_s2   <= prod_c_s1;
		prod_r_s2   <= prod_r_s1;
		q_ram_s2    <= q_rd;
		r_ram_s2    <= r_rd;
	end

	logic signed [SUM_W-1:0] q_old, r_old;
	logic [SUM_W:0]          q_add, r_add;
	logic                    load_ok, mat_ok, read_ok, sat_next;

	always_comb begin
		if (wb1_q.q_we && wb1_q.q_addr == row_addr_s2) begin
			q_old = wb1_q.q_data;
		end else if (wb2_q.q_we && wb2_q.q_addr == row_addr_s2) begin
			q_old = wb2_q.q_data;
		end else begin
			q_old = q_ram_s2;
		end
		if (wb1_q.r_we && wb1_q.r_addr == r_addr_s2) begin
			r_old = wb1_q.r_data;
		end else if (wb2_q.r_we && wb2_q.r_addr == r_addr_s2) begin
			r_old = wb2_q.r_data;
		end else begin
			r_old = r_ram_s2;
		end

		q_add = sat_add(q_old, prod_c_s2);
		r_add = sat_add(r_old, prod_r_s2);

		load_ok = valid_s2 && op_s2 == OP_LOAD && row_ok_s2;
		mat_ok  = valid_s2 && op_s2 == OP_MAT && row_ok_s2 && col_ok_s2;
		read_ok = valid_s2 && op_s2 == OP_READ && row_ok_s2;

		wr.p_we   = load_ok;
		wr.p_addr = row_addr_s2;
		wr.p_data = elem_s2;
		wr.q_we   = load_ok || mat_ok;
		wr.q_addr = row_addr_s2;
		wr.q_data = load_ok ? qi_s2 : q_add[SUM_W-1:0];
		wr.r_we   = load_ok || mat_ok;
		wr.r_addr = r_addr_s2;
		wr.r_data = load_ok ? ri_s2 : r_add[SUM_W-1:0];

		sat_next = sat_q || (mat_ok && (q_add[SUM_W] || r_add[SUM_W]));

		res.row_sum_out    = read_ok ? q_old : '0;
		res.col_sum_out    = read_ok ? r_old : '0;
		res.saturated_seen = sat_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			sat_q    <= 1'b0;
			wb1_q    <= '0;
			wb2_q    <= '0;
		end else begin
			valid_s2 <= valid_s1;
			sat_q    <= sat_next;
			wb1_q    <= wr;
			wb2_q    <= wb1_q;
		end
	end

	assign res_valid       = valid_s2;
	assign status.s1_valid = valid_s1;
	assign status.s2_valid = valid_s2;

	a_stage_advance: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> valid_s2)
		else $error("stage 1 item did not reach stage 2");

	a_sat_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		sat_q |=> sat_q)
		else $error("saturation flag cleared");

	a_write_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.q_we || wr.r_we || wr.p_we) |-> valid_s2)
		else $error("memory write without a stage 2 item");
endmodule

### src/mvta_out_queue.sv
module mvta_out_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  mvta_pkg::result_t      push_data,
	input  mvta_pkg::pipe_status_t status,
	output logic                   can_accept,
	output logic                   out_valid,
	input  logic                   out_ready,
	output mvta_pkg::result_t      out_data
);
	import mvta_pkg::*;

	localparam int PW = $clog2(OQ_DEPTH);
	localparam int CW = $clog2(OQ_DEPTH + 1);
	localparam int SW = CW + 1;

	result_t       mem_q [OQ_DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;
	logic [SW-1:0] inflight;
	logic          pop;

	always_comb begin
		out_valid  = count_q != '0;
		pop        = out_valid && out_ready;
		out_data   = mem_q[rptr_q];
		// reserve a slot for every item still in the pipeline
		inflight   = SW'(count_q) + SW'(status.s1_valid) + SW'(status.s2_valid);
		can_accept = inflight < SW'(OQ_DEPTH);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(OQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(OQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != CW'(OQ_DEPTH)))
		else $error("result queue overflow");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("result queue count mismatch");
endmodule

### src/matvec_and_transpose_accumulate.sv
// Matrix-vector and transpose-vector accumulator: q += A*p and r += A^T*p.
// req channel: one item per handshake. operation selects load (p entry plus
// starting q and r at row_index), matrix element (A[row][col]) or read
// (q and r at row_index). rsp channel: exactly one item per request item, in
// order; sums are zero except for an in-range read, saturated_seen is the
// sticky saturation flag after the item.
// Path: RAM read and multiply, then the saturating add, which writes the
// result queue that drives rsp. Throughput: one item per cycle while
// req.ready is high; the read-modify-write loop on the sum RAMs is closed
// by write-back bypassing.
// When rsp stalls, results collect in a four-entry queue; req.ready drops
// once queued plus in-flight items fill it, so nothing is lost.
// Reset clears the pipeline, the queue and the saturation flag. Vector and
// sum RAMs are not cleared: entries must be loaded before use.
module matvec_and_transpose_accumulate #(
	parameter int VEC_LEN = mvta_pkg::VEC_LEN_DEF
) (
	input logic        clk,
	input logic        arst_n,
	mvta_req_if.sink   req,
	mvta_rsp_if.source rsp
);
	import mvta_pkg::*;

	item_t        item;
	result_t      res, out_data;
	logic         res_valid, item_valid;
	pipe_status_t status;

	always_comb begin
		item.operation     = req.operation;
		item.row_index     = req.row_index;
		item.col_index     = req.col_index;
		item.element_value = req.element_value;
		item.row_sum_init  = req.row_sum_init;
		item.col_sum_init  = req.col_sum_init;
		item_valid         = req.valid && req.ready;
	end

	mvta_core #(.VEC_LEN(VEC_LEN)) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item(item),
		.res_valid(res_valid),
		.res(res),
		.status(status)
	);

	mvta_out_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_valid),
		.push_data(res),
		.status(status),
		.can_accept(req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.out_data(out_data)
	);

	assign rsp.row_sum_out    = out_data.row_sum_out;
	assign rsp.col_sum_out    = out_data.col_sum_out;
	assign rsp.saturated_seen = out_data.saturated_seen;
endmodule

### verif/matvec_and_transpose_accumulate_test.sv
module matvec_and_transpose_accumulate_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mvta_pkg::*;

	localparam logic [OP_W-1:0] OP_NONE = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ITEMS = 576;

	class sum_tracker;
		logic signed [ELEM_W-1:0] p_vec [VEC_LEN_DEF];
		logic signed [SUM_W-1:0]  q_vec [VEC_LEN_DEF];
		logic signed [SUM_W-1:0]  r_vec [VEC_LEN_DEF];
		bit                       sat_flag;
		result_t                  pending_sums [$];
		int                       errors;

		function new();
			sat_flag = 1'b0;
			errors = 0;
		endfunction

		function void log_error(string msg);
			errors++;
			if (errors <= 10)
				$display("%s", msg);
		endfunction

		function logic signed [SUM_W-1:0] acc_sat(logic signed [SUM_W-1:0] acc,
			logic signed [SUM_W-1:0] inc);
			logic [SUM_W:0] wide;
			wide = {acc[SUM_W-1], acc} + {inc[SUM_W-1], inc};
			if (wide[SUM_W] != wide[SUM_W-1]) begin
				sat_flag = 1'b1;
				return wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
			end
			return wide[SUM_W-1:0];
		endfunction

		function void note_item(item_t it);
			result_t                 sums;
			logic signed [SUM_W-1:0] elem;
			logic signed [SUM_W-1:0] pc;
			logic signed [SUM_W-1:0] pr;
			sums = '0;
			case (it.operation)
				OP_LOAD: begin
					p_vec[it.row_index] = it.element_value;
					q_vec[it.row_index] = it.row_sum_init;
					r_vec[it.row_index] = it.col_sum_init;
				end
				OP_MAT: begin
					elem = $signed(it.element_value);
					pc = $signed(p_vec[it.col_index]);
					pr = $signed(p_vec[it.row_index]);
					q_vec[it.row_index] = acc_sat(q_vec[it.row_index], elem * pc);
					r_vec[it.col_index] = acc_sat(r_vec[it.col_index], elem * pr);
				end
				OP_READ: begin
					sums.row_sum_out = q_vec[it.row_index];
					sums.col_sum_out = r_vec[it.row_index];
				end
				default: ;
			endcase
			sums.saturated_seen = sat_flag;
			pending_sums.push_back(sums);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_sums.size() == 0) begin
				log_error($sformatf("unexpected result q=%h r=%h sat=%b",
					got.row_sum_out, got.col_sum_out, got.saturated_seen));
				return;
			end
			want = pending_sums.pop_front();
			if (got.row_sum_out !== want.row_sum_out || got.col_sum_out !== want.col_sum_out ||
				got.saturated_seen !== want.saturated_seen)
				log_error($sformatf("mismatch: expected q=%h r=%h sat=%b, got q=%h r=%h sat=%b",
					want.row_sum_out, want.col_sum_out, want.saturated_seen,
					got.row_sum_out, got.col_sum_out, got.saturated_seen));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	mvta_req_if req_ch ();
	mvta_rsp_if rsp_ch ();

	matvec_and_transpose_accumulate dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	sum_tracker sb = new();

	int send_idle_pct;
	int rcv_idle_pct;
	int stall_cycles = 0;
	bit loaded [VEC_LEN_DEF];
	int loaded_idx [$];

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		result_t got;
		item_t   seen;
		bit      moved;
		moved = 1'b0;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.row_sum_out = rsp_ch.row_sum_out;
				got.col_sum_out = rsp_ch.col_sum_out;
				got.saturated_seen = rsp_ch.saturated_seen;
				sb.check_result(got);
				moved = 1'b1;
			end
			if (req_ch.valid && req_ch.ready) begin
				seen.operation = req_ch.operation;
				seen.row_index = req_ch.row_index;
				seen.col_index = req_ch.col_index;
				seen.element_value = req_ch.element_value;
				seen.row_sum_init = req_ch.row_sum_init;
				seen.col_sum_init = req_ch.col_sum_init;
				sb.note_item(seen);
				moved = 1'b1;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
			stall_cycles <= moved ? 0 : stall_cycles + 1;
		end
		rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	function automatic logic signed [ELEM_W-1:0] rand_elem();
		logic signed [15:0] tiny;
		tiny = 16'($urandom());
		case ($urandom_range(3))
			0: return $urandom();
			1: return ELEM_W'(tiny);
			2: begin
				case ($urandom_range(4))
					0: return 32'sh7FFF_FFFF;
					1: return 32'sh8000_0000;
					2: return 32'sh0000_0000;
					3: return 32'sh0001_0000;
					default: return -32'sd1;
				endcase
			end
			default: return $urandom_range(0, 32'h0003_FFFF);
		endcase
	endfunction

	function automatic logic signed [SUM_W-1:0] rand_sum();
		logic signed [39:0] mid;
		mid = 40'({$urandom(), $urandom()});
		case ($urandom_range(3))
			0: return {$urandom(), $urandom()};
			1: return SUM_W'(mid);
			2: begin
				if ($urandom_range(1))
					return 64'sh7FFF_FFFF_FFFF_FFFF - $urandom_range(0, 1000);
				return 64'sh8000_0000_0000_0000 + $urandom_range(0, 1000);
			end
			default: return '0;
		endcase
	endfunction

	function automatic item_t noise_item();
		item_t it;
		it.operation = OP_W'($urandom());
		it.row_index = IDX_W'($urandom());
		it.col_index = IDX_W'($urandom());
		it.element_value = $urandom();
		it.row_sum_init = {$urandom(), $urandom()};
		it.col_sum_init = {$urandom(), $urandom()};
		return it;
	endfunction

	function automatic item_t mk_load(logic [IDX_W-1:0] idx, logic signed [ELEM_W-1:0] p,
		logic signed [SUM_W-1:0] q, logic signed [SUM_W-1:0] r);
		item_t it;
		it = noise_item();
		it.operation = OP_LOAD;
		it.row_index = idx;
		it.element_value = p;
		it.row_sum_init = q;
		it.col_sum_init = r;
		if (!loaded[idx]) begin
			loaded[idx] = 1'b1;
			loaded_idx.push_back(int'(idx));
		end
		return it;
	endfunction

	function automatic item_t mk_mat(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
		logic signed [ELEM_W-1:0] elem);
		item_t it;
		it = noise_item();
		it.operation = OP_MAT;
		it.row_index = row;
		it.col_index = col;
		it.element_value = elem;
		return it;
	endfunction

	function automatic item_t mk_read(logic [IDX_W-1:0] idx);
		item_t it;
		it = noise_item();
		it.operation = OP_READ;
		it.row_index = idx;
		return it;
	endfunction

	function automatic logic [IDX_W-1:0] pick_loaded();
		return IDX_W'(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)]);
	endfunction

	function automatic item_t random_item();
		int               roll;
		item_t            it;
		logic [IDX_W-1:0] row;
		roll = $urandom_range(99);
		if (loaded_idx.size() == 0 || roll < 20) begin
			row = ($urandom_range(99) < 60) ? IDX_W'($urandom_range(0, 15)) :
				IDX_W'($urandom_range(0, 255));
			return mk_load(row, rand_elem(), rand_sum(), rand_sum());
		end
		if (roll < 75) begin
			row = pick_loaded();
			return mk_mat(row, ($urandom_range(9) == 0) ? row : pick_loaded(), rand_elem());
		end
		if (roll < 95)
			return mk_read(pick_loaded());
		it = noise_item();
		it.operation = OP_NONE;
		return it;
	endfunction

	task automatic send(item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.operation <= it.operation;
		req_ch.row_index <= it.row_index;
		req_ch.col_index <= it.col_index;
		req_ch.element_value <= it.element_value;
		req_ch.row_sum_init <= it.row_sum_init;
		req_ch.col_sum_init <= it.col_sum_init;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_sums.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(int n);
		repeat (n) begin
			send(random_item());
			if ($urandom_range(199) == 0)
				drain();
		end
		drain();
	endtask

	initial begin
		item_t it;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.operation = '0;
		req_ch.row_index = '0;
		req_ch.col_index = '0;
		req_ch.element_value = '0;
		req_ch.row_sum_init = '0;
		req_ch.col_sum_init = '0;
		send_idle_pct = 6;
		rcv_idle_pct = 48;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, diagonal, unused selector, then saturation both ways
		send(mk_load(8'd0, 32'sh0001_0000, 64'sd0, 64'sd0));
		send(mk_load(8'd255, 32'sh7FFF_FFFF, 64'sh7FFF_FFFF_FFFF_FFF0,
			64'sh8000_0000_0000_0010));
		send(mk_load(8'd1, 32'sh8000_0000, -64'sd1, 64'sd1));
		send(mk_load(8'd128, 32'sh0000_0000, 64'sh0000_0001_0000_0000, -64'sd5));
		send(mk_mat(8'd0, 8'd0, 32'sh0002_0000));
		send(mk_mat(8'd0, 8'd1, 32'sh7FFF_FFFF));
		send(mk_read(8'd0));
		send(mk_read(8'd1));
		it = '1;
		send(it);
		send(mk_mat(8'd128, 8'd0, -32'sd1));
		send(mk_read(8'd128));
		send(mk_mat(8'd255, 8'd255, 32'sh7FFF_FFFF));
		send(mk_read(8'd255));
		send(mk_mat(8'd1, 8'd1, 32'sh8000_0000));
		send(mk_mat(8'd255, 8'd1, 32'sh8000_0000));
		send(mk_read(8'd255));
		send(mk_read(8'd1));
		send(mk_load(8'd2, 32'sh7FFF_FFFF, 64'sh8000_0000_0000_0000,
			64'sh8000_0000_0000_0001));
		send(mk_mat(8'd2, 8'd2, 32'sh8000_0000));
		send(mk_read(8'd2));
		it = '0;
		it.operation = OP_NONE;
		send(it);
		send(mk_read(8'd0));
		drain();

		run_phase(PHASE_ITEMS);
		send_idle_pct = 48;
		rcv_idle_pct <= 6;
		run_phase(PHASE_ITEMS);
		send_idle_pct = 0;
		rcv_idle_pct <= 0;
		run_phase(PHASE_ITEMS);

		repeat (8) @(posedge clk);
		if (sb.pending_sums.size() != 0)
			sb.log_error($sformatf("%0d results never arrived", sb.pending_sums.size()));
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
